>>> rtl/dfia_pkg.sv
// ----------------------------------------------------------------------------
// dfia_pkg
// shared constants, codes and controller/datapath interface types for the
// deferred free index allocator
// ----------------------------------------------------------------------------
package dfia_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int POOL_COUNT = 4;

  localparam int IDX_W   = $clog2(POOL_DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int POOL_W  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int MEM_AW  = POOL_W + IDX_W;
  localparam int MEM_DEPTH = POOL_COUNT * POOL_DEPTH;

  localparam int CAP_W     = 11;
  localparam int REG_COUNT = 4;
  localparam int PADDR_W   = $clog2(REG_COUNT) + 2;

  // command modes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_APPLY   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_ABSENT   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_REPLY,
    OP_ALLOC,
    OP_ALLOC_OUT,
    OP_RELEASE,
    OP_AP_INIT,
    OP_AP_READ,
    OP_AP_WRITE,
    OP_AP_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] code;
    logic       drop;
    logic       sel_ptr;
  } dp_cmd_t;

  typedef struct packed {
    logic absent;
    logic empty;
    logic pend_full;
    logic free_full;
    logic k_left;
    logic last;
  } dp_stat_t;

endpackage

>>> rtl/dfia_datapath.sv
// ----------------------------------------------------------------------------
// dfia_datapath
// pool counters, free and pending stack memories, config registers and the
// result register
// ----------------------------------------------------------------------------
module dfia_datapath import dfia_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [1:0]           heap_type,
  input  logic [IDX_W-1:0]     index,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 done,
  output logic [1:0]           status,
  output logic [IDX_W-1:0]     index_out
);

  logic [CNT_W-1:0] cap [POOL_COUNT];
  logic [CNT_W-1:0] fc  [POOL_COUNT];
  logic [CNT_W-1:0] lo  [POOL_COUNT];
  logic [CNT_W-1:0] pc  [POOL_COUNT];

  logic [POOL_W-1:0] ptr;
  logic [CNT_W-1:0]  k;
  logic              ovf;
  logic [IDX_W-1:0]  alloc_pos;
  logic              alloc_id;

  logic [IDX_W-1:0] free_mem [MEM_DEPTH];
  logic [IDX_W-1:0] pend_mem [MEM_DEPTH];
  logic [IDX_W-1:0] free_rd;
  logic [IDX_W-1:0] pend_rd;

  logic [POOL_W-1:0] sel;
  logic              ht_ok;
  logic [CNT_W-1:0]  fc_m1;
  logic              cfg_we;
  logic              cfg_ok;
  logic [POOL_W-1:0] cfg_pool;
  logic [CAP_W-1:0]  cfg_raw;
  logic [CNT_W-1:0]  cfg_n;
  logic              ap_ovf;

  assign sel   = cmd.sel_ptr ? ptr : POOL_W'(heap_type);
  assign ht_ok = 32'(heap_type) < 32'(POOL_COUNT);
  assign fc_m1 = fc[sel] - CNT_W'(1);

  assign stat.absent    = !ht_ok || (cap[sel] == '0);
  assign stat.empty     = (fc[sel] == '0);
  assign stat.pend_full = (pc[sel] == CNT_W'(POOL_DEPTH));
  assign stat.free_full = (fc[sel] == CNT_W'(POOL_DEPTH));
  assign stat.k_left    = (k < pc[sel]);
  assign stat.last      = (ptr == POOL_W'(POOL_COUNT - 1));

  // config port: capacity saturates at pool depth
  assign cfg_we   = psel && penable && pwrite;
  assign cfg_ok   = 32'(paddr[PADDR_W-1:2]) < 32'(POOL_COUNT);
  assign cfg_pool = POOL_W'(paddr[PADDR_W-1:2]);
  assign cfg_raw  = pwdata[CAP_W-1:0];
  assign cfg_n    = (32'(cfg_raw) > 32'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH) : CNT_W'(cfg_raw);
  assign prdata   = cfg_ok ? 32'(cap[cfg_pool]) : '0;

  assign ap_ovf = ovf || cmd.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        cap[p] <= '0;
        fc[p]  <= '0;
        lo[p]  <= '0;
        pc[p]  <= '0;
      end
      ptr       <= '0;
      k         <= '0;
      ovf       <= 1'b0;
      done      <= 1'b0;
      status    <= ST_OK;
      index_out <= '0;
      alloc_pos <= '0;
      alloc_id  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we && cfg_ok) begin
        // positions below lo were never written since this fill: identity
        cap[cfg_pool] <= cfg_n;
        fc[cfg_pool]  <= cfg_n;
        lo[cfg_pool]  <= cfg_n;
        pc[cfg_pool]  <= '0;
      end
      unique case (cmd.op)
        OP_NONE: begin
        end
        OP_REPLY: begin
          done      <= 1'b1;
          status    <= cmd.code;
          index_out <= '0;
        end
        OP_ALLOC: begin
          fc[sel]   <= fc_m1;
          alloc_pos <= fc_m1[IDX_W-1:0];
          alloc_id  <= fc_m1 < lo[sel];
        end
        OP_ALLOC_OUT: begin
          done      <= 1'b1;
          status    <= ST_OK;
          index_out <= alloc_id ? alloc_pos : free_rd;
        end
        OP_RELEASE: begin
          pc[sel]   <= pc[sel] + CNT_W'(1);
          done      <= 1'b1;
          status    <= ST_OK;
          index_out <= '0;
        end
        OP_AP_INIT: begin
          ptr <= '0;
          k   <= '0;
          ovf <= 1'b0;
        end
        OP_AP_READ: begin
          k <= k + CNT_W'(1);
        end
        OP_AP_WRITE: begin
          fc[sel] <= fc[sel] + CNT_W'(1);
          if (fc[sel] < lo[sel]) begin
            lo[sel] <= fc[sel];
          end
        end
        OP_AP_NEXT: begin
          pc[sel] <= '0;
          k       <= '0;
          ptr     <= ptr + POOL_W'(1);
          ovf     <= ap_ovf;
          if (stat.last) begin
            done      <= 1'b1;
            status    <= ap_ovf ? ST_OVERFLOW : ST_OK;
            index_out <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // free stack memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_AP_WRITE) begin
      free_mem[{sel, fc[sel][IDX_W-1:0]}] <= pend_rd;
    end
    if (cmd.op == OP_ALLOC) begin
      free_rd <= free_mem[{sel, fc_m1[IDX_W-1:0]}];
    end
  end

  // pending stack memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RELEASE) begin
      pend_mem[{sel, pc[sel][IDX_W-1:0]}] <= index;
    end
    if (cmd.op == OP_AP_READ) begin
      pend_rd <= pend_mem[{sel, k[IDX_W-1:0]}];
    end
  end

endmodule

>>> rtl/dfia_ctrl.sv
// ----------------------------------------------------------------------------
// dfia_ctrl
// command decode and sequencing of allocate readout and the apply walk
// ----------------------------------------------------------------------------
module dfia_ctrl import dfia_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  dp_stat_t   stat,
  output logic       busy,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_RESP     = 4'b0010,
    S_AP_CHECK = 4'b0100,
    S_AP_WRITE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.op      = OP_NONE;
    cmd.code    = ST_OK;
    cmd.drop    = 1'b0;
    cmd.sel_ptr = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_ALLOC: begin
              if (stat.absent) begin
                cmd.op   = OP_REPLY;
                cmd.code = ST_ABSENT;
              end else if (stat.empty) begin
                cmd.op   = OP_REPLY;
                cmd.code = ST_EMPTY;
              end else begin
                cmd.op     = OP_ALLOC;
                state_next = S_RESP;
              end
            end
            MODE_RELEASE: begin
              if (stat.absent) begin
                cmd.op   = OP_REPLY;
                cmd.code = ST_ABSENT;
              end else if (stat.pend_full) begin
                cmd.op   = OP_REPLY;
                cmd.code = ST_OVERFLOW;
              end else begin
                cmd.op = OP_RELEASE;
              end
            end
            MODE_APPLY: begin
              cmd.op     = OP_AP_INIT;
              state_next = S_AP_CHECK;
            end
            default: begin
              cmd.op   = OP_REPLY;
              cmd.code = ST_OK;
            end
          endcase
        end
      end
      S_RESP: begin
        cmd.op     = OP_ALLOC_OUT;
        state_next = S_IDLE;
      end
      S_AP_CHECK: begin
        if (stat.k_left && !stat.free_full) begin
          cmd.op     = OP_AP_READ;
          state_next = S_AP_WRITE;
        end else begin
          // no pending words left, or free stack full: the rest of this pool's pending words are dropped
          cmd.op     = OP_AP_NEXT;
          cmd.drop   = stat.k_left;
          state_next = stat.last ? S_IDLE : S_AP_CHECK;
        end
      end
      S_AP_WRITE: begin
        cmd.op     = OP_AP_WRITE;
        state_next = S_AP_CHECK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/deferred_free_index_allocator.sv
// ----------------------------------------------------------------------------
// deferred_free_index_allocator
// index pools with free stacks and deferred release through pending stacks
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                      payload
// command   in         start & !busy                  mode, heap_type, index
// result    out        done (one cycle, no stall)     status, index_out
// config    in         psel & penable & pwrite        paddr, pwdata / prdata
//
// - release, a rejected allocate and mode 3: result in the cycle after accept,
//   busy stays low, one word per cycle
// - a successful allocate: busy through S_RESP; result follows the registered free stack read
// - apply: an init step, then for each pool one pending read / free write pair
//   per moved entry and a pool step; the stack memories are single-port
// - reset (synchronous, rst) empties all pools; no clearing pass is needed
// - the result port has no back pressure: done marks a word for one cycle
//
module deferred_free_index_allocator import dfia_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [1:0]         heap_type,
  input  logic [IDX_W-1:0]   index,
  output logic               done,
  output logic [1:0]         status,
  output logic [IDX_W-1:0]   index_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // config access never waits
  assign pready = 1'b1;

  // sequencer: decodes accepted commands, walks pools on apply
  dfia_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // counters, stack memories, capacity registers, result register
  dfia_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .heap_type (heap_type),
    .index     (index),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .done      (done),
    .status    (status),
    .index_out (index_out)
  );

`ifndef SYNTHESIS
  // only a successful allocate carries a nonzero index
  a_idx_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK) || (index_out == '0))
    else $error("nonzero index on failed result");

  // a release word is answered in the next cycle
  a_release_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_RELEASE) |=> done)
    else $error("release result missing");

  // every result stems from an accepted word or ongoing work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy) || $past(busy))
    else $error("spurious result");

  // apply always runs the pool walk
  a_apply_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_APPLY) |=> busy && !done)
    else $error("apply did not start walk");
`endif

endmodule
